### hw/rtl/lsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_pkg - shared definitions for the 3x3 cross-kernel sharpening block
// Sizes, register indexes, input codes and stage records.
// ----------------------------------------------------------------------------
package lsh_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int FW_W       = 12;
    localparam int HT_W       = 16;
    // common width for column/width compares and the flush count
    localparam int CMP_W      = (COL_W + 1 > FW_W) ? COL_W + 1 : FW_W;
    localparam int PIX_W      = 8;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DEPTH  = 3;
    localparam int OPTR_W     = $clog2(OUT_DEPTH);
    localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
    localparam logic [HT_W-1:0] FRAME_HEIGHT_RST = HT_W'(480);

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             pixel;
        logic             emit;
        logic             interior;
        logic             last;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pix;
    } t_stage;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_result;

endpackage

### hw/rtl/lsh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_ram - simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/laplacian_sharpen_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_top - 3x3 cross-kernel sharpening of a grayscale stream
// Raster-order pixels in, sharpened raster-order pixels out, border as zero.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one item per pixel, mode pixel,
//   then W+1 flush items after the last pixel of the frame. Output channel
//   (o_out_valid / i_out_ready): one result per pixel from row 1, column 1
//   on, each one row up and one column left, then one zero per flush item;
//   the last flush result carries o_last_of_frame.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 frame
//   width, index 1 frame height; write between frames.
//   Throughput: one item per clock while o_in_ready is high. Both line
//   buffers share one RAM entry per column; it is read in the accept
//   cycle and written back the next.
//   Reset clears position counters, window and result queue; the line RAM
//   is not cleared and needs no clearing pass.
//   Receiver stall: results collect in a three-entry queue; o_in_ready
//   drops once queued and in-flight results would fill it.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_mode,
    input  logic [lsh_pkg::PIX_W-1:0]      i_pixel_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [lsh_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                           o_last_of_frame,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lsh_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsh_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [lsh_pkg::FW_W-1:0]     r_frame_width;
    logic [lsh_pkg::HT_W-1:0]     r_frame_height;
    logic [lsh_pkg::HT_W-1:0]     r_row,   n_row;
    logic [lsh_pkg::COL_W-1:0]    r_col,   n_col;
    logic [lsh_pkg::CMP_W-1:0]    r_flush, n_flush;
    lsh_pkg::t_stage              r_b,     n_b;
    logic [lsh_pkg::PIX_W-1:0]    r_win0, r_win1, r_win2, r_win3;
    lsh_pkg::t_result             r_fifo [lsh_pkg::OUT_DEPTH];
    logic [lsh_pkg::OPTR_W-1:0]   r_wptr, r_rptr;
    logic [lsh_pkg::OCNT_W-1:0]   r_cnt;

    logic [lsh_pkg::CMP_W-1:0]    fw_ext, eff_w, col_ext, col_inc, flush_inc;
    logic [lsh_pkg::HT_W-1:0]     eff_h, eff_r;
    logic [lsh_pkg::COL_W-1:0]    eff_c;
    logic                         row_done, wrap, pix_drop, accept, rd_en;
    logic [lsh_pkg::LINE_W-1:0]   rdata;
    logic [lsh_pkg::PIX_W-1:0]    mid, up;
    logic [10:0]                  five_c;
    logic [9:0]                   neg_sum;
    logic signed [11:0]           diff;
    logic [lsh_pkg::PIX_W-1:0]    sharp;
    logic                         push, pop;
    logic [lsh_pkg::OCNT_W:0]     pending;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lsh_pkg::FRAME_WIDTH_RST;
            r_frame_height <= lsh_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == lsh_pkg::REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data[lsh_pkg::FW_W-1:0];
            end else if (i_cfg_index == lsh_pkg::REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data[lsh_pkg::HT_W-1:0];
            end
        end
    end

    // ---------------- stage A: position tracking, RAM read ----------------
    assign fw_ext = lsh_pkg::CMP_W'(r_frame_width);
    assign eff_w  = (fw_ext < lsh_pkg::CMP_W'(3)) ? lsh_pkg::CMP_W'(3) :
                    (fw_ext > lsh_pkg::CMP_W'(lsh_pkg::MAX_WIDTH)) ?
                    lsh_pkg::CMP_W'(lsh_pkg::MAX_WIDTH) : fw_ext;
    assign eff_h  = (r_frame_height < lsh_pkg::HT_W'(3)) ? lsh_pkg::HT_W'(3)
                                                         : r_frame_height;

    assign row_done  = (r_row >= eff_h);
    assign col_ext   = lsh_pkg::CMP_W'(r_col);
    // column beyond a reduced width: the row counts as complete
    assign wrap      = (col_ext >= eff_w);
    assign eff_r     = wrap ? r_row + lsh_pkg::HT_W'(1) : r_row;
    assign eff_c     = wrap ? '0 : r_col;
    assign pix_drop  = row_done || (wrap && (eff_r >= eff_h));
    assign col_inc   = lsh_pkg::CMP_W'(eff_c) + lsh_pkg::CMP_W'(1);
    assign flush_inc = r_flush + lsh_pkg::CMP_W'(1);

    assign pending    = (lsh_pkg::OCNT_W + 1)'(r_cnt) +
                        (lsh_pkg::OCNT_W + 1)'(r_b.valid & r_b.emit);
    assign o_in_ready = (pending < (lsh_pkg::OCNT_W + 1)'(lsh_pkg::OUT_DEPTH));
    assign accept     = i_in_valid && o_in_ready;
    assign rd_en      = accept && (i_mode == lsh_pkg::MODE_PIXEL) && !pix_drop;

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_flush = r_flush;
        n_b     = '0;
        if (accept) begin
            if (i_mode == lsh_pkg::MODE_FLUSH) begin
                if (row_done) begin
                    n_b.valid = 1'b1;
                    n_b.emit  = 1'b1;
                    if (flush_inc >= eff_w + lsh_pkg::CMP_W'(1)) begin
                        n_b.last = 1'b1;
                        n_row    = '0;
                        n_col    = '0;
                        n_flush  = '0;
                    end else begin
                        n_flush = flush_inc;
                    end
                end
            end else if (!row_done) begin
                if (pix_drop) begin
                    n_col = '0;
                    n_row = eff_r;
                end else begin
                    n_b.valid    = 1'b1;
                    n_b.pixel    = 1'b1;
                    n_b.emit     = (eff_r >= lsh_pkg::HT_W'(2)) ||
                                   ((eff_r == lsh_pkg::HT_W'(1)) && (eff_c != '0));
                    n_b.interior = (eff_r >= lsh_pkg::HT_W'(2)) &&
                                   (eff_c >= lsh_pkg::COL_W'(2));
                    n_b.col      = eff_c;
                    n_b.pix      = i_pixel_in;
                    if (col_inc >= eff_w) begin
                        n_col = '0;
                        n_row = eff_r + lsh_pkg::HT_W'(1);
                    end else begin
                        n_col = col_inc[lsh_pkg::COL_W-1:0];
                        n_row = eff_r;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_flush <= '0;
            r_b     <= '0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_flush <= n_flush;
            r_b     <= n_b;
        end
    end

    // Entry holds {upper, middle} for one column. Consecutive items touch
    // different columns (width at least 3), so the write-back of one item
    // never meets the read of the next.
    lsh_ram #(
        .WIDTH (lsh_pkg::LINE_W),
        .DEPTH (lsh_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_b.valid & r_b.pixel),
        .i_waddr (r_b.col),
        .i_wdata ({mid, r_b.pix}),
        .i_re    (rd_en),
        .i_raddr (eff_c),
        .o_rdata (rdata)
    );

    // ---------------- stage B: kernel, window shift, write-back ----------------
    assign mid = rdata[lsh_pkg::PIX_W-1:0];
    assign up  = rdata[lsh_pkg::LINE_W-1:lsh_pkg::PIX_W];

    assign five_c  = {1'b0, r_win1, 2'b00} + 11'(r_win1);
    assign neg_sum = 10'(r_win0) + 10'(mid) + 10'(r_win2) + 10'(r_win3);
    assign diff    = $signed({1'b0, five_c}) - $signed({2'b00, neg_sum});

    always_comb begin
        if (!r_b.interior || diff < 12'sd0) begin
            sharp = '0;
        end else if (diff > 12'sd255) begin
            sharp = '1;
        end else begin
            sharp = diff[lsh_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
            r_win2 <= '0;
            r_win3 <= '0;
        end else if (r_b.valid && r_b.pixel) begin
            r_win0 <= r_win1;
            r_win1 <= mid;
            r_win2 <= up;
            r_win3 <= r_b.pix;
        end
    end

    // ---------------- result queue ----------------
    assign push = r_b.valid && r_b.emit;
    assign pop  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= '{pixel: sharp, last: r_b.last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == lsh_pkg::OPTR_W'(lsh_pkg::OUT_DEPTH - 1)) ?
                          '0 : r_wptr + lsh_pkg::OPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= (r_rptr == lsh_pkg::OPTR_W'(lsh_pkg::OUT_DEPTH - 1)) ?
                          '0 : r_rptr + lsh_pkg::OPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + lsh_pkg::OCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - lsh_pkg::OCNT_W'(1);
            end
        end
    end

    assign o_out_valid     = (r_cnt != '0);
    assign o_pixel_out     = r_fifo[r_rptr].pixel;
    assign o_last_of_frame = r_fifo[r_rptr].last;

endmodule

### hw/rtl/lsh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsh_checker - port-level checks for the sharpening block
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
module lsh_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [lsh_pkg::PIX_W-1:0] o_pixel_out,
    input logic                      o_last_of_frame
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_pixel_out) && $stable(o_last_of_frame)))
        else $error("result changed while stalled");

    // end of frame is a border position, always zero
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_frame) |-> (o_pixel_out == '0))
        else $error("end-of-frame result not zero");

    // an empty queue refills only from an item accepted earlier, via stage B
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without an accepted item");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

endmodule

bind laplacian_sharpen_3x3_top lsh_checker u_lsh_checker (.*);

### bench/laplacian_sharpen_3x3_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_top_tb - self-checking bench for the sharpening block
// Streams raster frames of random and hand-picked pixels under several frame
// sizes. A cycle-free model of the line buffers and cross window predicts
// every output pixel, and each result is checked in order as it leaves.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top_tb;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;

    // indexes past the two sizes, written to check they are ignored
    localparam logic [lsh_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = lsh_pkg::CFG_IDX_W'(2);
    localparam logic [lsh_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = lsh_pkg::CFG_IDX_W'(3);

    localparam bit PRED  = 1'b0;
    localparam bit TYPED = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [lsh_pkg::PIX_W-1:0] pix;
        bit                        typed;
        logic [lsh_pkg::PIX_W-1:0] want_pix;
        logic                      want_last;
    } t_dir_row;

    // Two 3x3 frames: bright centre on black saturates high, dark centre on
    // white saturates low. Early flush and a pixel past the frame are dropped.
    localparam t_dir_row DIR_ROWS [28] = '{
        {lsh_pkg::MODE_FLUSH, 8'hA5,  PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   TYPED, 8'd255, 1'b0},
        {lsh_pkg::MODE_PIXEL, 8'h5A,  PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'h00,  TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'hFF,  TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'h00,  TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'hFF,  TYPED, 8'd0,   1'b1},
        {lsh_pkg::MODE_PIXEL, 8'd255, PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, PRED,  8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd0,   TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_PIXEL, 8'd255, TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'h00,  TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'h00,  TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'h00,  TYPED, 8'd0,   1'b0},
        {lsh_pkg::MODE_FLUSH, 8'h00,  TYPED, 8'd0,   1'b1}
    };

    logic                           i_clk           = 1'b0;
    logic                           i_rst_n         = 1'b0;
    logic                           i_in_valid      = 1'b0;
    logic                           o_in_ready;
    logic                           i_mode          = lsh_pkg::MODE_PIXEL;
    logic [lsh_pkg::PIX_W-1:0]      i_pixel_in      = '0;
    logic                           o_out_valid;
    logic                           i_out_ready     = 1'b0;
    logic [lsh_pkg::PIX_W-1:0]      o_pixel_out;
    logic                           o_last_of_frame;
    logic                           i_cfg_valid     = 1'b0;
    logic                           o_cfg_ready;
    logic [lsh_pkg::CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [lsh_pkg::CFG_DATA_W-1:0] i_cfg_data      = '0;

    laplacian_sharpen_3x3_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_pixel_in      (i_pixel_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_out     (o_pixel_out),
        .o_last_of_frame (o_last_of_frame),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---- sharpening predictor state
    logic [lsh_pkg::FW_W-1:0]  width_cfg;
    logic [lsh_pkg::HT_W-1:0]  height_cfg;
    logic [lsh_pkg::PIX_W-1:0] upper_row [lsh_pkg::MAX_WIDTH];
    logic [lsh_pkg::PIX_W-1:0] middle_row [lsh_pkg::MAX_WIDTH];
    logic [lsh_pkg::PIX_W-1:0] cross_px [4];
    int                        row_pos;
    int                        col_pos;
    int                        flush_cnt;

    lsh_pkg::t_result pending_pixels [$];
    int               mismatches   = 0;
    int               snd_idle_pct = 0;
    int               rcv_idle_pct = 0;
    int               stall_cycles = 0;

    function automatic int frame_w();
        if (width_cfg < 3) return 3;
        if (width_cfg > lsh_pkg::MAX_WIDTH) return lsh_pkg::MAX_WIDTH;
        return int'(width_cfg);
    endfunction

    function automatic int frame_h();
        return (height_cfg < 3) ? 3 : int'(height_cfg);
    endfunction

    // Advance the predictor by one item; returns 1 when the item yields a pixel.
    function automatic bit sharpen_predict(input logic m,
                                           input logic [lsh_pkg::PIX_W-1:0] p,
                                           output lsh_pkg::t_result res);
        int                        w;
        int                        h;
        int                        c;
        int                        r;
        int                        ci;
        int                        v;
        logic [lsh_pkg::PIX_W-1:0] up;
        logic [lsh_pkg::PIX_W-1:0] mid;
        bit                        emit;
        w   = frame_w();
        h   = frame_h();
        res = '0;
        if (m == lsh_pkg::MODE_FLUSH) begin
            if (row_pos < h) return 1'b0;
            flush_cnt = (flush_cnt + 1) & 'hFFF;
            if (flush_cnt >= w + 1) begin
                res.last  = 1'b1;
                row_pos   = 0;
                col_pos   = 0;
                flush_cnt = 0;
            end
            return 1'b1;
        end
        if (row_pos >= h) return 1'b0;
        // width cut below the current column: close the row
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) return 1'b0;
        end
        c    = col_pos;
        r    = row_pos;
        ci   = (c < lsh_pkg::MAX_WIDTH) ? c : 0;
        up   = upper_row[ci];
        mid  = middle_row[ci];
        emit = (r >= 2) || (r == 1 && c >= 1);
        v    = 0;
        if (r >= 2 && c >= 2) begin
            v = 5 * int'(cross_px[1]) - int'(cross_px[0]) - int'(mid)
                - int'(cross_px[2]) - int'(cross_px[3]);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
        end
        cross_px[0]    = cross_px[1];
        cross_px[1]    = mid;
        cross_px[2]    = up;
        cross_px[3]    = p;
        upper_row[ci]  = mid;
        middle_row[ci] = p;
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
        end
        if (!emit) return 1'b0;
        res.pixel = v[lsh_pkg::PIX_W-1:0];
        return 1'b1;
    endfunction

    function automatic logic [lsh_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ---- drivers
    task automatic push_item(input logic m, input logic [lsh_pkg::PIX_W-1:0] p,
                             input bit typed = 1'b0,
                             input lsh_pkg::t_result typed_want = '0);
        lsh_pkg::t_result res;
        bit               hit;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_pixel_in <= p;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        hit = sharpen_predict(m, p, res);
        if (typed) pending_pixels.push_back(typed_want);
        else if (hit) pending_pixels.push_back(res);
    endtask

    task automatic write_reg(input logic [lsh_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lsh_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == lsh_pkg::REG_FRAME_WIDTH) width_cfg = data[lsh_pkg::FW_W-1:0];
        else if (idx == lsh_pkg::REG_FRAME_HEIGHT) height_cfg = data[lsh_pkg::HT_W-1:0];
    endtask

    // Drop valid, wait for every pending pixel, then let the pipe empty.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Finish the frame (stray flushes mixed in), drop a few surplus items, then flush.
    task automatic feed_frame();
        while (row_pos < frame_h()) begin
            if ($urandom_range(0, 19) == 0) push_item(lsh_pkg::MODE_FLUSH, random_pixel());
            push_item(lsh_pkg::MODE_PIXEL, random_pixel());
        end
        repeat ($urandom_range(0, 2)) push_item(lsh_pkg::MODE_PIXEL, random_pixel());
        while (row_pos != 0) push_item(lsh_pkg::MODE_FLUSH, random_pixel());
    endtask

    task automatic pick_sizes();
        logic [lsh_pkg::CFG_DATA_W-1:0] wd;
        logic [lsh_pkg::CFG_DATA_W-1:0] hd;
        quiesce();
        wd = {4'($urandom), 12'($urandom_range(3, 12))};
        if ($urandom_range(0, 9) == 0) begin
            wd[lsh_pkg::FW_W-1:0] = lsh_pkg::FW_W'($urandom_range(0, 2));
        end
        hd = 16'($urandom_range(3, 8));
        if ($urandom_range(0, 9) == 0) hd = 16'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0: write_reg(lsh_pkg::REG_FRAME_WIDTH, wd);
            1: write_reg(lsh_pkg::REG_FRAME_HEIGHT, hd);
            2: begin
                write_reg(lsh_pkg::REG_FRAME_HEIGHT, hd);
                write_reg(lsh_pkg::REG_FRAME_WIDTH, wd);
            end
            default: begin
                write_reg(lsh_pkg::REG_FRAME_WIDTH, wd);
                write_reg(lsh_pkg::REG_FRAME_HEIGHT, hd);
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_frames(input int budget);
        int fed;
        fed = 0;
        while (fed < budget) begin
            pick_sizes();
            fed += frame_w() * frame_h() + frame_w() + 1;
            feed_frame();
        end
    endtask

    // Tallest frame, then cut the height below the row reached.
    task automatic cut_height_midframe();
        int rows;
        rows = $urandom_range(3, 6);
        quiesce();
        write_reg(lsh_pkg::REG_FRAME_WIDTH, 16'($urandom_range(3, 9)));
        write_reg(lsh_pkg::REG_FRAME_HEIGHT, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        repeat (rows * frame_w()) push_item(lsh_pkg::MODE_PIXEL, random_pixel());
        quiesce();
        write_reg(lsh_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(0, rows)));
        i_cfg_valid <= 1'b0;
        feed_frame();
    endtask

    // Narrow the frame while a row is part-way through.
    task automatic cut_width_midrow();
        int cut_col;
        cut_col = $urandom_range(4, 9);
        quiesce();
        write_reg(lsh_pkg::REG_FRAME_WIDTH, 16'd10);
        write_reg(lsh_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(4, 6)));
        i_cfg_valid <= 1'b0;
        repeat (2 * 10 + cut_col) push_item(lsh_pkg::MODE_PIXEL, random_pixel());
        quiesce();
        write_reg(lsh_pkg::REG_FRAME_WIDTH, 16'($urandom_range(0, cut_col)));
        i_cfg_valid <= 1'b0;
        feed_frame();
    endtask

    // ---- result side: random back-pressure and in-order check
    always @(posedge i_clk) begin
        lsh_pkg::t_result want;
        i_out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: pixel expected none, actual %0d last %0b",
                         $time, o_pixel_out, o_last_of_frame);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_out !== want.pixel) begin
                    mismatches++;
                    $display("%0t: pixel expected %0d, actual %0d",
                             $time, want.pixel, o_pixel_out);
                end
                if (o_last_of_frame !== want.last) begin
                    mismatches++;
                    $display("%0t: last_of_frame expected %0b, actual %0b",
                             $time, want.last, o_last_of_frame);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        width_cfg  = lsh_pkg::FRAME_WIDTH_RST;
        height_cfg = lsh_pkg::FRAME_HEIGHT_RST;
        foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        foreach (cross_px[i]) cross_px[i] = '0;
        row_pos   = 0;
        col_pos   = 0;
        flush_cnt = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 8;
        rcv_idle_pct = 49;
        // reset sizes: one full row and a pixel, a flush that the open frame
        // drops, then cut both sizes and finish the frame at the new sizes
        repeat (frame_w() + 1) push_item(lsh_pkg::MODE_PIXEL, random_pixel());
        push_item(lsh_pkg::MODE_FLUSH, random_pixel());
        quiesce();
        write_reg(lsh_pkg::REG_FRAME_HEIGHT, 16'($urandom_range(0, 3)));
        write_reg(lsh_pkg::REG_FRAME_WIDTH, 16'($urandom_range(0, 2)));
        i_cfg_valid <= 1'b0;
        feed_frame();

        quiesce();
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'h0000);
        write_reg(lsh_pkg::REG_FRAME_WIDTH, 16'hF003);
        write_reg(lsh_pkg::REG_FRAME_HEIGHT, 16'd3);
        i_cfg_valid <= 1'b0;
        foreach (DIR_ROWS[i]) begin
            push_item(DIR_ROWS[i].mode, DIR_ROWS[i].pix, DIR_ROWS[i].typed,
                      '{pixel: DIR_ROWS[i].want_pix, last: DIR_ROWS[i].want_last});
        end
        random_frames(400);

        quiesce();
        snd_idle_pct = 49;
        rcv_idle_pct = 8;
        cut_height_midframe();
        cut_width_midrow();
        random_frames(400);

        quiesce();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_frames(400);

        quiesce();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
